// File: design/assert_macros.svh
// assertion macros shared by the quadrature decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define QDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QDS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QDS_ASSERT(lbl, prop, msg)
`define QDS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: design/qds_pkg.sv
// types and constants for the quadrature decoder with speed measurement
package qds_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_PERIOD   = 2'd1;

    localparam logic [CFG_W-1:0] CPR_RESET    = 16'd4096;
    localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd100;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    // indexed by {previous ab, current ab}, a is the high bit
    localparam logic [1:0] STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    localparam logic [OUT_W-1:0] SPEED_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SPEED_NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } spd_status_t;

endpackage

// File: design/quadrature_decoder_speed_top.sv
// top level of the x4 quadrature decoder with periodic speed measurement
// an item without a completed speed period goes from acceptance to S_DONE and then into the output register
// an item that completes a speed period passes through S_SPEED and waits there for the speed unit
// the speed path is set by the 32-step divider; output stalls hold an item in S_DONE on either path
// one item is in work at a time; the next is taken once the result is in the output register
// reset clears the internal position, flags, counters and speed and loads the register defaults

`include "assert_macros.svh"

module quadrature_decoder_speed_top
    import qds_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    pin_a,
    input  logic                    pin_b,
    input  logic                    index_pin,
    input  logic                    ms_tick,
    input  logic                    clear,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] position,
    output logic                    index_seen,
    output logic signed [OUT_W-1:0] speed_rps_q16,
    output logic                    speed_updated,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int EXT_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPEED,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       cpr_reg;
    logic [CFG_W-1:0]       period_reg;
    logic [1:0]             prev_ab_reg;
    logic                   primed_reg;
    logic [COUNT_WIDTH-1:0] pos_reg;
    logic                   index_flag_reg;
    logic                   prev_index_reg;
    logic [15:0]            ms_counter_reg;
    logic [COUNT_WIDTH-1:0] period_start_reg;
    logic [OUT_W-1:0]       speed_value_reg;
    logic                   updated_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       position_reg;
    logic                   index_seen_reg;
    logic [OUT_W-1:0]       speed_out_reg;
    logic                   speed_updated_reg;

    logic [1:0]             cur_ab;
    logic [1:0]             step;
    logic [COUNT_WIDTH-1:0] pos_step;
    logic [COUNT_WIDTH-1:0] pos_next;
    logic                   idx_rise;
    logic [CFG_W-1:0]       cpr_eff;
    logic [CFG_W-1:0]       per_eff;
    logic [15:0]            ms_inc;
    logic                   period_done;
    logic [COUNT_WIDTH-1:0] delta;
    logic                   accept;
    logic                   spd_start;
    logic                   out_free;
    logic [EXT_W-1:0]       pos_ext;
    spd_status_t            spd_status;
    logic [OUT_W-1:0]       spd_result;

    assign cur_ab      = {pin_a, pin_b};
    assign step        = STEP_TABLE[{prev_ab_reg, cur_ab}];
    assign idx_rise    = primed_reg & index_pin & ~prev_index_reg;
    assign cpr_eff     = (cpr_reg == '0) ? CFG_W'(1) : cpr_reg;
    assign per_eff     = (period_reg == '0) ? CFG_W'(1) : period_reg;
    assign ms_inc      = ms_counter_reg + 16'd1;
    assign period_done = ms_tick & ((ms_inc >= per_eff) | (ms_inc == 16'd0));
    assign delta       = pos_next - period_start_reg;
    assign accept      = in_valid & (state_reg == S_IDLE);
    assign spd_start   = accept & ~clear & period_done;
    assign out_free    = ~out_valid_reg | ~out_stall;
    assign pos_ext     = EXT_W'($signed(pos_reg));

    always_comb
    begin
        case (step)
            STEP_UP:   pos_step = pos_reg + COUNT_WIDTH'(1);
            STEP_DOWN: pos_step = pos_reg - COUNT_WIDTH'(1);
            default:   pos_step = pos_reg;
        endcase
        pos_next = primed_reg ? pos_step : pos_reg;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign position      = position_reg;
    assign index_seen    = index_seen_reg;
    assign speed_rps_q16 = speed_out_reg;
    assign speed_updated = speed_updated_reg;

    qds_speed_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_speed (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (spd_start),
        .delta   (delta),
        .cpr_eff (cpr_eff),
        .per_eff (per_eff),
        .status  (spd_status),
        .result  (spd_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cpr_reg           <= CPR_RESET;
            period_reg        <= PERIOD_RESET;
            prev_ab_reg       <= '0;
            primed_reg        <= 1'b0;
            pos_reg           <= '0;
            index_flag_reg    <= 1'b0;
            prev_index_reg    <= 1'b0;
            ms_counter_reg    <= '0;
            period_start_reg  <= '0;
            speed_value_reg   <= '0;
            updated_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_COUNTS_PER_REV: cpr_reg    <= cfg_data;
                    REG_SPEED_PERIOD:   period_reg <= cfg_data;
                    default:            ;
                endcase
            end

            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prev_ab_reg    <= cur_ab;
                        prev_index_reg <= index_pin;
                        primed_reg     <= 1'b1;
                        updated_reg    <= 1'b0;
                        if (clear)
                        begin
                            pos_reg          <= '0;
                            speed_value_reg  <= '0;
                            index_flag_reg   <= 1'b0;
                            ms_counter_reg   <= '0;
                            period_start_reg <= '0;
                            state_reg        <= S_DONE;
                        end
                        else
                        begin
                            pos_reg <= pos_next;
                            if (idx_rise)
                            begin
                                index_flag_reg <= 1'b1;
                            end
                            if (period_done)
                            begin
                                ms_counter_reg   <= '0;
                                period_start_reg <= pos_next;
                                state_reg        <= S_SPEED;
                            end
                            else
                            begin
                                if (ms_tick)
                                begin
                                    ms_counter_reg <= ms_inc;
                                end
                                state_reg <= S_DONE;
                            end
                        end
                    end
                end
                S_SPEED:
                begin
                    if (spd_status.done)
                    begin
                        speed_value_reg <= spd_result;
                        updated_reg     <= 1'b1;
                        state_reg       <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        position_reg      <= pos_ext[OUT_W-1:0];
                        index_seen_reg    <= index_flag_reg;
                        speed_out_reg     <= speed_value_reg;
                        speed_updated_reg <= updated_reg;
                        out_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `QDS_ASSERT(a_clear_zeroes, accept && clear |=> speed_value_reg == '0 && !index_flag_reg && pos_reg == '0, "clear left state behind")
    `QDS_ASSERT(a_start_free, spd_start |-> !spd_status.busy, "speed unit started while busy")
    `QDS_ASSERT(a_done_waited, spd_status.done |-> state_reg == S_SPEED, "speed result with no waiting transaction")
    `QDS_ASSERT(a_out_from_done, $rose(out_valid_reg) |-> $past(state_reg) == S_DONE, "result shown out of sequence")

endmodule

// File: design/qds_speed_unit.sv
// iterative speed calculation: scale, overflow check and restoring division
`include "assert_macros.svh"

module qds_speed_unit
    import qds_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] delta,
    input  logic [CFG_W-1:0]       cpr_eff,
    input  logic [CFG_W-1:0]       per_eff,
    output spd_status_t            status,
    output logic [OUT_W-1:0]       result
);

    localparam int NUM_W = COUNT_WIDTH + 10;
    localparam int HI_W  = NUM_W - 16;
    localparam int CMP_W = (HI_W > 32) ? HI_W : 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_NUM,
        S_CHK,
        S_DIV,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic [COUNT_WIDTH-1:0] delta_reg;
    logic [COUNT_WIDTH-1:0] mag_reg;
    logic                   neg_reg;
    logic [31:0]            den_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [31:0]            rem_reg;
    logic [31:0]            lo_reg;
    logic [31:0]            quo_reg;
    logic                   sat_reg;
    logic [4:0]             cnt_reg;

    logic [HI_W-1:0]  num_hi;
    logic [CMP_W-1:0] num_hi_ext;
    logic [CMP_W-1:0] den_ext;
    logic [NUM_W-1:0] mag_ext;
    logic [32:0]      rem_shift;
    logic [33:0]      diff;
    logic             ge;

    assign num_hi     = num_reg[NUM_W-1:16];
    assign num_hi_ext = CMP_W'(num_hi);
    assign den_ext    = CMP_W'(den_reg);
    assign mag_ext    = NUM_W'(mag_reg);
    assign rem_shift  = {rem_reg, lo_reg[31]};
    assign diff       = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge         = ~diff[33];

    assign status.busy = (state_reg != S_IDLE);
    assign status.done = (state_reg == S_FIN);

    always_comb
    begin
        if (sat_reg)
        begin
            result = neg_reg ? SPEED_NEG_MAX : SPEED_POS_MAX;
        end
        else if (neg_reg)
        begin
            result = (quo_reg > SPEED_NEG_MAX) ? SPEED_NEG_MAX : (32'd0 - quo_reg);
        end
        else
        begin
            result = (quo_reg > SPEED_POS_MAX) ? SPEED_POS_MAX : quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        delta_reg <= delta;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    neg_reg   <= delta_reg[COUNT_WIDTH-1];
                    mag_reg   <= delta_reg[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - delta_reg)
                                                          : delta_reg;
                    den_reg   <= {16'd0, cpr_eff} * {16'd0, per_eff};
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    // times 1000 as 1024 - 16 - 8
                    num_reg   <= (mag_ext << 10) - (mag_ext << 4) - (mag_ext << 3);
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    sat_reg   <= (num_hi_ext >= den_ext);
                    rem_reg   <= num_hi_ext[31:0];
                    lo_reg    <= {num_reg[15:0], 16'd0};
                    quo_reg   <= '0;
                    cnt_reg   <= 5'd31;
                    state_reg <= (num_hi_ext >= den_ext) ? S_FIN : S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= ge ? diff[31:0] : rem_shift[31:0];
                    lo_reg  <= {lo_reg[30:0], 1'b0};
                    quo_reg <= {quo_reg[30:0], ge};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `QDS_ASSERT(a_start_idle, start |-> state_reg == S_IDLE, "speed unit restarted while busy")
    `QDS_ASSERT(a_rem_below_den, state_reg == S_DIV |-> rem_reg < den_reg, "partial remainder not below divisor")
    `QDS_ASSERT(a_fin_source, state_reg == S_FIN |-> $past(state_reg) == S_DIV || $past(state_reg) == S_CHK, "finish reached out of sequence")

endmodule
